### design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, state types and round helpers.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned COUNT_W     = 61;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } sha_state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } round_ctl_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### design/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message bytes and digests.
// ----------------------------------------------------------------------------
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
    logic [31:0] digest_word5;
    logic [31:0] digest_word6;
    logic [31:0] digest_word7;
    modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                    digest_word4, digest_word5, digest_word6, digest_word7, input ready);
    modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                    digest_word4, digest_word5, digest_word6, digest_word7, output ready);
endinterface

### design/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round per cycle while busy, on a shared datapath, with a rolling
// 16-word schedule window loaded from the block buffer.
// ----------------------------------------------------------------------------
module sha256_round
    import sha256_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  round_ctl_t         ctl,
    input  logic [5:0]         t,
    input  logic [511:0]       block,
    input  logic [255:0]       chain,
    output logic [255:0]       vars
);
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] w, s1, s0, ch, mj, t1, t2, x2, x15, g0, g1;
    logic [3:0]  wi;

    assign wi  = t[3:0];
    assign x2  = w_reg[4'(wi - 4'd2)];
    assign x15 = w_reg[4'(wi - 4'd15)];
    assign g1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    assign g0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);

    always_comb
    begin
        if (t < 6'd16)
            w = block[511 - 32*wi -: 32];
        else
            w = g1 + w_reg[4'(wi - 4'd7)] + g0 + w_reg[wi];
        s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + round_k(t) + w;
        s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= chain[255 - 32*i -: 32];
        end
        else if (ctl.busy)
        begin
            w_reg[wi] <= w;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            vars[255 - 32*i -: 32] = v_reg[i];
    end

    logic unused_ok;
    assign unused_ok = rst_n & ctl.done;
endmodule

### design/sha256_stream_hash.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Byte stream in, digest out; sequencer around a one-round-per-cycle unit.
// ----------------------------------------------------------------------------
// Sequence: a byte that does not complete a block is taken in IDLE; a full block
// then passes through ROUND and FOLD. End of message adds one or two padded
// blocks, each through PAD, ROUND and FOLD, then the digest beat is held until taken.
// Input takes one byte beat per cycle while a block fills; each full block then
// stalls input while the shared round unit runs its rounds and the fold.
// Reset (rst_n low, async) loads the initial hash values and clears count.
module sha256_stream_hash
    import sha256_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha256_in_if.sink    in_ch,
    sha256_out_if.source out_ch
);
    sha_state_t  state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [5:0]  t_reg;
    logic [31:0] wbuf_reg [16];
    logic [31:0] pad_w [16];
    logic [31:0] h_reg [8];
    logic        eom_reg;   // padding pending after this block
    logic        final_reg; // this block is the length block
    logic        tail_reg;  // length block still to build after this block
    logic [511:0] block;
    logic [255:0] chain, vars;
    round_ctl_t  ctl;
    logic        in_fire, blk_full;
    logic [5:0]  pos;
    logic [63:0] bits;

    assign in_fire  = in_ch.valid & in_ch.ready;
    assign blk_full = in_ch.has_byte & (count_reg[5:0] == 6'd63);
    assign pos      = count_reg[5:0];
    assign bits     = {count_reg, 3'b000};

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            block[511 - 32*i -: 32] = wbuf_reg[i];
        for (int i = 0; i < 8; i++)
            chain[255 - 32*i -: 32] = h_reg[i];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire)
                          if (blk_full) state_next = ST_ROUND;
                          else if (in_ch.end_of_message) state_next = ST_PAD;
            ST_ROUND: if (t_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD:  state_next = final_reg ? ST_OUT
                                 : ((eom_reg || tail_reg) ? ST_PAD : ST_IDLE);
            ST_PAD:   state_next = ST_ROUND;
            ST_OUT:   if (out_ch.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.start   = (state_next == ST_ROUND) && (state_reg != ST_ROUND);
        ctl.busy    = (state_reg == ST_ROUND);
        ctl.done    = (state_reg == ST_FOLD);
        in_ch.ready = (state_reg == ST_IDLE);
        out_ch.valid = (state_reg == ST_OUT);
    end

    sha256_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .t     (t_reg),
        .block (block),
        .chain (chain),
        .vars  (vars)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            t_reg     <= '0;
            eom_reg   <= 1'b0;
            final_reg <= 1'b0;
            tail_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_h(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            t_reg <= ctl.busy ? 6'(t_reg + 6'd1) : 6'd0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_fire)
                    begin
                        if (in_ch.has_byte)
                            count_reg <= count_reg + 1'b1;
                        eom_reg   <= in_ch.end_of_message;
                        final_reg <= 1'b0;
                    end
                ST_FOLD:
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + vars[255 - 32*i -: 32];
                ST_PAD:
                    begin
                        // room for the length only if 0x80 landed before byte 56
                        final_reg <= (pos < 6'd56) || !eom_reg;
                        tail_reg  <= eom_reg && (pos >= 6'd56);
                        eom_reg   <= 1'b0;
                    end
                ST_OUT:
                    if (out_ch.ready)
                    begin
                        count_reg <= '0;
                        for (int i = 0; i < 8; i++)
                            h_reg[i] <= init_h(3'(i));
                    end
                default: ;
            endcase
        end
    end

    // Padded block: 0x80 at pos, zeros after it, length in the last two words
    // when it fits; a length-only block is zeros plus the length.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 4; j++)
                if ((!eom_reg || pos < 6'd56) && i >= 14)
                    pad_w[i][31 - 8*j -: 8] = (i == 14) ? bits[63 - 8*j -: 8]
                                                        : bits[31 - 8*j -: 8];
                else if (eom_reg && 6'(4*i + j) == pos)
                    pad_w[i][31 - 8*j -: 8] = PAD_BYTE;
                else if (!eom_reg || 6'(4*i + j) > pos)
                    pad_w[i][31 - 8*j -: 8] = 8'h00;
                else
                    pad_w[i][31 - 8*j -: 8] = wbuf_reg[i][31 - 8*j -: 8];
    end

    // Block buffer: bytes land at pos; padding writes the padded tail in the PAD state.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire && in_ch.has_byte)
            wbuf_reg[pos[5:2]][31 - 8*pos[1:0] -: 8] <= in_ch.data_byte;
        else if (state_reg == ST_PAD)
        begin
            for (int i = 0; i < 16; i++)
                wbuf_reg[i] <= pad_w[i];
        end
    end

    assign out_ch.digest_word0 = h_reg[0];
    assign out_ch.digest_word1 = h_reg[1];
    assign out_ch.digest_word2 = h_reg[2];
    assign out_ch.digest_word3 = h_reg[3];
    assign out_ch.digest_word4 = h_reg[4];
    assign out_ch.digest_word5 = h_reg[5];
    assign out_ch.digest_word6 = h_reg[6];
    assign out_ch.digest_word7 = h_reg[7];

`ifndef SYNTHESIS
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && t_reg != 6'd63) |=> (state_reg == ST_ROUND))
        else $error("round sequence cut short");
    a_fold_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> ($past(state_reg) == ST_ROUND && $past(t_reg) == 6'd63))
        else $error("fold without 64 rounds");
    a_out_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready) |=> (count_reg == '0))
        else $error("count not cleared after digest");
`endif
endmodule
